### src/ecpad_pkg.sv
// ----------------------------------------------------------------------------
// ecpad_pkg - shared constants for the elliptic-curve point add/double block
// Register indexes, reset values and operation codes.
// ----------------------------------------------------------------------------
`default_nettype none
package ecpad_pkg;

  // Configuration register indexes
  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_COEFF_A = 1'b1;

  // Register reset values
  localparam logic [31:0] MODULUS_RESET = 32'd4294967291;
  localparam logic [31:0] COEFF_A_RESET = 32'd0;

  // Operation codes
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_DBL = 1'b1;

endpackage
`default_nettype wire

### src/ec_point_add_double.sv
// ----------------------------------------------------------------------------
// ec_point_add_double - affine point addition / doubling over GF(modulus)
// Bit-serial modular arithmetic: every product and reduction is a
// double-and-add pass one bit per cycle; the inverse is extended Euclid with
// a restoring bit-serial divider.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid in_ready op p_x p_y p_inf q_x ... | into block
//  out     | out_valid out_ready r_x r_y r_inf          | out of block
//  cfg     | psel penable pwrite paddr pwdata prdata pready | APB slave
//
// One item at a time. The five operands are reduced first, then up to four
// products are formed on the serial double-and-add unit, and the inverse
// takes one quotient bit per divider step in each Euclid round.
// The serial double-and-add unit and the Euclid round count set the run time.
// A new item is taken while a finished result still waits at the output.
// Reset is synchronous; it restores the registers and empties the block.
// ----------------------------------------------------------------------------
`default_nettype none
module ec_point_add_double #(
  parameter int FIELD_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  op,
  input  wire logic [FIELD_BITS-1:0] p_x,
  input  wire logic [FIELD_BITS-1:0] p_y,
  input  wire logic                  p_inf,
  input  wire logic [FIELD_BITS-1:0] q_x,
  input  wire logic [FIELD_BITS-1:0] q_y,
  input  wire logic                  q_inf,
  // output channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [FIELD_BITS-1:0]      r_x,
  output logic [FIELD_BITS-1:0]      r_y,
  output logic                       r_inf,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int W  = FIELD_BITS;
  localparam int KW = $clog2(W);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STEP  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_ICHK  = 3'd3;
  localparam logic [2:0] S_ALIGN = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_UPD   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  // Program steps
  localparam logic [3:0] P_START = 4'd0;
  localparam logic [3:0] P_RPX   = 4'd1;
  localparam logic [3:0] P_RPY   = 4'd2;
  localparam logic [3:0] P_RQX   = 4'd3;
  localparam logic [3:0] P_RQY   = 4'd4;
  localparam logic [3:0] P_RA    = 4'd5;
  localparam logic [3:0] P_N1    = 4'd6;
  localparam logic [3:0] P_N2    = 4'd7;
  localparam logic [3:0] P_N3    = 4'd8;
  localparam logic [3:0] P_SLOPE = 4'd9;
  localparam logic [3:0] P_SQ    = 4'd10;
  localparam logic [3:0] P_RX1   = 4'd11;
  localparam logic [3:0] P_RX2   = 4'd12;
  localparam logic [3:0] P_RY    = 4'd13;

  // Modular add, both operands below m
  function automatic logic [W-1:0] addm(input logic [W-1:0] x, input logic [W-1:0] y,
                                        input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[W-1:0];
  endfunction

  // Modular subtract, both operands below m
  function automatic logic [W-1:0] subm(input logic [W-1:0] x, input logic [W-1:0] y,
                                        input logic [W-1:0] m);
    return (x >= y) ? (x - y) : (x + (m - y));
  endfunction

  // One double-and-add step
  function automatic logic [W-1:0] horner(input logic [W-1:0] acc, input logic b,
                                          input logic [W-1:0] a, input logic [W-1:0] m);
    logic [W-1:0] d;
    d = addm(acc, acc, m);
    return b ? addm(d, a, m) : d;
  endfunction

  // Fit a 32-bit register value to the field width
  function automatic logic [W-1:0] fit(input logic [31:0] v);
    logic [63:0] e;
    e = {32'd0, v};
    return e[W-1:0];
  endfunction

  function automatic logic [31:0] unfit(input logic [W-1:0] v);
    logic [63:0] e;
    e = 64'(v);
    return e[31:0];
  endfunction

  logic [W-1:0]  modulus, coeff_a;
  logic [2:0]    state;
  logic [3:0]    pc;
  logic          rop, rpinf, rqinf;
  logic [W-1:0]  px, py, qx, qy, ra, num, s, tmp, rx;
  logic [W-1:0]  acc, mul_a, mul_b;
  logic [KW-1:0] cnt;
  logic [W-1:0]  r0, r1, t0, t1, d, rem;
  logic [W-1:0]  res_x, res_y;
  logic          res_inf;
  logic          cfg_wr;
  logic          div_bit;

  assign pready   = 1'b1;
  assign in_ready = (state == S_IDLE);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign div_bit  = (rem >= d);

  // Register reads
  always_comb begin
    case (paddr[2])
      ecpad_pkg::REG_MODULUS: prdata = unfit(modulus);
      ecpad_pkg::REG_COEFF_A: prdata = unfit(coeff_a);
      default:                prdata = 32'd0;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= fit(ecpad_pkg::MODULUS_RESET);
      coeff_a <= fit(ecpad_pkg::COEFF_A_RESET);
    end else if (cfg_wr) begin
      case (paddr[2])
        ecpad_pkg::REG_MODULUS: modulus <= fit(pwdata);
        ecpad_pkg::REG_COEFF_A: coeff_a <= fit(pwdata);
        default: ;
      endcase
    end
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= P_START;
      out_valid <= 1'b0;
    end else begin
      // load a finished result when the output is free, drop it once transferred
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            rop   <= op;
            rpinf <= p_inf;
            rqinf <= q_inf;
            px    <= p_x;
            py    <= p_y;
            qx    <= q_x;
            qy    <= q_y;
            pc    <= P_START;
            state <= S_STEP;
          end
        end
        S_MUL: begin
          acc   <= horner(acc, mul_b[W-1], mul_a, modulus);
          mul_b <= {mul_b[W-2:0], 1'b0};
          if (cnt == '0) begin
            state <= S_STEP;
          end else begin
            cnt <= cnt - KW'(1);
          end
        end
        S_ICHK: begin
          if (r1 == '0) begin
            if (r0 != W'(1)) begin
              res_x <= '0; res_y <= '0; res_inf <= 1'b1; state <= S_DONE;
            end else begin
              // slope = num * inverse
              acc <= '0; mul_a <= num; mul_b <= t0; cnt <= KW'(W - 1);
              pc <= P_SLOPE; state <= S_MUL;
            end
          end else begin
            d     <= r1;
            cnt   <= '0;
            state <= S_ALIGN;
          end
        end
        S_ALIGN: begin
          if ({d, 1'b0} <= {1'b0, r0}) begin
            d   <= {d[W-2:0], 1'b0};
            cnt <= cnt + KW'(1);
          end else begin
            rem   <= r0;
            acc   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // one quotient bit; accumulate quotient times t1
          if (div_bit) begin
            rem <= rem - d;
          end
          acc <= horner(acc, div_bit, t1, modulus);
          if (cnt == '0) begin
            state <= S_UPD;
          end else begin
            d   <= {1'b0, d[W-1:1]};
            cnt <= cnt - KW'(1);
          end
        end
        S_UPD: begin
          r0    <= r1;
          r1    <= rem;
          t0    <= t1;
          t1    <= subm(t0, acc, modulus);
          state <= S_ICHK;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            r_x   <= res_x;
            r_y   <= res_y;
            r_inf <= res_inf;
            state <= S_IDLE;
          end
        end
        default: begin
          // S_STEP: one program step, reading the last product from acc
          case (pc)
            P_START: begin
              if (modulus < W'(2)) begin
                res_x <= '0; res_y <= '0; res_inf <= 1'b1; state <= S_DONE;
              end else begin
                acc <= '0; mul_a <= W'(1); mul_b <= px; cnt <= KW'(W - 1);
                pc <= P_RPX; state <= S_MUL;
              end
            end
            P_RPX: begin
              px <= acc; acc <= '0; mul_a <= W'(1); mul_b <= py; cnt <= KW'(W - 1);
              pc <= P_RPY; state <= S_MUL;
            end
            P_RPY: begin
              py <= acc; acc <= '0; mul_a <= W'(1); mul_b <= qx; cnt <= KW'(W - 1);
              pc <= P_RQX; state <= S_MUL;
            end
            P_RQX: begin
              qx <= acc; acc <= '0; mul_a <= W'(1); mul_b <= qy; cnt <= KW'(W - 1);
              pc <= P_RQY; state <= S_MUL;
            end
            P_RQY: begin
              qy <= acc; acc <= '0; mul_a <= W'(1); mul_b <= coeff_a; cnt <= KW'(W - 1);
              pc <= P_RA; state <= S_MUL;
            end
            P_RA: begin
              ra <= acc;
              if (rop == ecpad_pkg::OP_ADD) begin
                if (rpinf) begin
                  res_inf <= rqinf;
                  res_x   <= rqinf ? '0 : qx;
                  res_y   <= rqinf ? '0 : qy;
                  state   <= S_DONE;
                end else if (rqinf) begin
                  res_x <= px; res_y <= py; res_inf <= 1'b0; state <= S_DONE;
                end else if (px == qx) begin
                  res_x <= '0; res_y <= '0; res_inf <= 1'b1; state <= S_DONE;
                end else begin
                  num <= subm(py, qy, modulus);
                  r0  <= modulus; r1 <= subm(px, qx, modulus);
                  t0  <= '0; t1 <= W'(1);
                  state <= S_ICHK;
                end
              end else begin
                if (rpinf || py == '0) begin
                  res_x <= '0; res_y <= '0; res_inf <= 1'b1; state <= S_DONE;
                end else begin
                  acc <= '0; mul_a <= px; mul_b <= px; cnt <= KW'(W - 1);
                  pc <= P_N1; state <= S_MUL;
                end
              end
            end
            P_N1: begin
              num <= addm(acc, acc, modulus); tmp <= acc;
              pc <= P_N2; state <= S_STEP;
            end
            P_N2: begin
              num <= addm(num, tmp, modulus); pc <= P_N3; state <= S_STEP;
            end
            P_N3: begin
              num <= addm(num, ra, modulus);
              pc <= P_START;
              r0 <= modulus; r1 <= addm(py, py, modulus);
              t0 <= '0; t1 <= W'(1);
              state <= S_ICHK;
            end
            P_SLOPE: begin
              s <= acc; mul_a <= acc; mul_b <= acc; acc <= '0; cnt <= KW'(W - 1);
              pc <= P_SQ; state <= S_MUL;
            end
            P_SQ: begin
              tmp <= subm(acc, px, modulus); pc <= P_RX1; state <= S_STEP;
            end
            P_RX1: begin
              rx <= subm(tmp, (rop == ecpad_pkg::OP_DBL) ? px : qx, modulus);
              pc <= P_RX2; state <= S_STEP;
            end
            P_RX2: begin
              acc <= '0; mul_a <= s; mul_b <= subm(px, rx, modulus); cnt <= KW'(W - 1);
              pc <= P_RY; state <= S_MUL;
            end
            P_RY: begin
              res_x <= rx; res_y <= subm(acc, py, modulus); res_inf <= 1'b0;
              state <= S_DONE;
            end
            default: begin
              res_x <= '0; res_y <= '0; res_inf <= 1'b1; state <= S_DONE;
            end
          endcase
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // an infinite result carries zero coordinates
  a_inf_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && r_inf) |-> (r_x == '0 && r_y == '0))
    else $error("infinite result with nonzero coordinates");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while busy");

  // the added operand of the serial unit stays reduced
  a_mul_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (mul_a < modulus))
    else $error("multiplicand not reduced");

  // divider remainder stays below twice the shifted divisor
  a_div_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> ({1'b0, rem} < {d, 1'b0}))
    else $error("divider out of range");
`endif

endmodule
`default_nettype wire

### tb/sv/ec_point_add_double_test.sv
// ----------------------------------------------------------------------------
// ec_point_add_double_test - self-checking bench for the affine point unit
// Writes several curve settings over the APB port. Drives directed requests
// under the reset setting, random add/double requests under each, with random
// gaps, output stalls; checks results on a 64-bit predictor of field arithmetic.
// ----------------------------------------------------------------------------
module ec_point_add_double_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 600;

  typedef struct packed {
    logic        op;
    logic [31:0] p_x;
    logic [31:0] p_y;
    logic        p_inf;
    logic [31:0] q_x;
    logic [31:0] q_y;
    logic        q_inf;
  } point_req_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic        inf;
  } point_res_t;

  // Expected points and the curve setting they are computed under
  class point_scoreboard;
    longint unsigned modulus = 64'(ecpad_pkg::MODULUS_RESET);
    longint unsigned coeff_a = 64'(ecpad_pkg::COEFF_A_RESET);
    point_res_t      expected_points[$];
    int              errors = 0;

    // Modular inverse by extended Euclid; 0 returned in ok when none exists
    function longint unsigned mod_inverse(longint unsigned v, output bit ok);
      longint r0, r1, t0, t1, q, tmp;
      r0 = modulus; r1 = v; t0 = 0; t1 = 1;
      while (r1 != 0) begin
        q = r0 / r1;
        tmp = r0 - q * r1; r0 = r1; r1 = tmp;
        tmp = t0 - q * t1; t0 = t1; t1 = tmp;
      end
      ok = (r0 == 1);
      if (t0 < 0) t0 += modulus;
      return t0;
    endfunction

    function point_res_t compute_point(point_req_t r);
      longint unsigned m, px, py, qx, qy, a, num, den, inv, s, rx, ry;
      point_res_t res;
      bit ok;
      m = modulus;
      res = '{x: '0, y: '0, inf: 1'b1};
      if (m < 2) return res;
      px = r.p_x % m; py = r.p_y % m; qx = r.q_x % m; qy = r.q_y % m;
      a = coeff_a % m;
      if (r.op == ecpad_pkg::OP_ADD) begin
        if (r.p_inf) begin
          if (!r.q_inf) res = '{x: 32'(qx), y: 32'(qy), inf: 1'b0};
          return res;
        end
        if (r.q_inf) return '{x: 32'(px), y: 32'(py), inf: 1'b0};
        if (px == qx) return res;
        num = (py + m - qy) % m;
        den = (px + m - qx) % m;
        inv = mod_inverse(den, ok);
        if (!ok) return res;
        s = (num * inv) % m;
        rx = ((s * s) % m + 2 * m - px - qx) % m;
      end else begin
        if (r.p_inf || py == 0) return res;
        num = (3 * ((px * px) % m) + a) % m;
        den = (2 * py) % m;
        inv = mod_inverse(den, ok);
        if (!ok) return res;
        s = (num * inv) % m;
        rx = ((s * s) % m + 2 * m - 2 * px) % m;
      end
      ry = ((s * ((px + m - rx) % m)) % m + m - py) % m;
      return '{x: 32'(rx), y: 32'(ry), inf: 1'b0};
    endfunction

    function void note_input(point_req_t r);
      expected_points.push_back(compute_point(r));
    endfunction

    function void check_result(point_res_t got);
      point_res_t want;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h inf=%b", $time, got.x, got.y, got.inf);
        errors++;
        return;
      end
      want = expected_points.pop_front();
      if (got.x !== want.x) begin
        $display("%0t: r_x expected %h actual %h", $time, want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: r_y expected %h actual %h", $time, want.y, got.y);
        errors++;
      end
      if (got.inf !== want.inf) begin
        $display("%0t: r_inf expected %b actual %b", $time, want.inf, got.inf);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        op = ecpad_pkg::OP_ADD;
  logic [31:0] p_x = '0, p_y = '0, q_x = '0, q_y = '0;
  logic        p_inf = 1'b0, q_inf = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] r_x, r_y;
  logic        r_inf;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  point_scoreboard points = new();
  int send_idle_pct = 23;
  int recv_idle_pct = 46;
  int sent_count = 0;
  int stall_cycles = 0;

  ec_point_add_double #(.FIELD_BITS(32)) DUT (
    .clk, .rst, .in_valid, .in_ready, .op, .p_x, .p_y, .p_inf, .q_x, .q_y, .q_inf,
    .out_valid, .out_ready, .r_x, .r_y, .r_inf,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Note accepted requests and check results at the edge they transfer
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      points.note_input('{op, p_x, p_y, p_inf, q_x, q_y, q_inf});
    if (!rst && out_valid && out_ready)
      points.check_result('{r_x, r_y, r_inf});
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Abort when nothing transfers for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[ec_point_add_double] ERROR");
      $finish;
    end
  end

  task automatic send_request(point_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {op, p_x, p_y, p_inf, q_x, q_y, q_inf} <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
    // Switch idling pattern by thirds of the run
    if (sent_count == 420) begin
      send_idle_pct = 46; recv_idle_pct = 23;
    end else if (sent_count == 840) begin
      send_idle_pct = 0; recv_idle_pct = 0;
    end
  endtask

  // Hold the sender until every expected point is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (points.expected_points.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == ecpad_pkg::REG_MODULUS) points.modulus = 64'(value);
    else points.coeff_a = 64'(value);
  endtask

  function automatic logic [31:0] pick_coord();
    longint unsigned m;
    m = points.modulus;
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return $urandom_range(1) ? 32'd0 : 32'(m - 1);
      2:       return $urandom_range(7);
      default: return 32'($urandom() % m);
    endcase
  endfunction

  function automatic point_req_t random_request();
    point_req_t r;
    r.op    = $urandom_range(1) ? ecpad_pkg::OP_DBL : ecpad_pkg::OP_ADD;
    r.p_x   = pick_coord();
    r.p_y   = ($urandom_range(19) == 0) ? 32'd0 : pick_coord();
    r.q_x   = ($urandom_range(9) == 0) ? r.p_x : pick_coord();
    r.q_y   = pick_coord();
    r.p_inf = ($urandom_range(11) == 0);
    r.q_inf = ($urandom_range(11) == 0);
    return r;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_request(random_request());
    drain_results();
  endtask

  initial begin
    point_req_t r;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests under the reset curve setting
    send_request('{ecpad_pkg::OP_ADD, 32'd1, 32'd2, 1'b0, 32'd3, 32'd4, 1'b0});
    send_request('{ecpad_pkg::OP_DBL, 32'd5, 32'd7, 1'b0, 32'd0, 32'd0, 1'b0});
    send_request('{ecpad_pkg::OP_ADD, 32'd9, 32'd9, 1'b1, 32'd11, 32'd12, 1'b0});
    send_request('{ecpad_pkg::OP_ADD, 32'd9, 32'd9, 1'b1, 32'd11, 32'd12, 1'b1});
    send_request('{ecpad_pkg::OP_ADD, 32'd9, 32'd8, 1'b0, 32'd11, 32'd12, 1'b1});
    send_request('{ecpad_pkg::OP_ADD, 32'd6, 32'd8, 1'b0, 32'd6, 32'd8, 1'b0});
    send_request('{ecpad_pkg::OP_ADD, 32'd6, 32'd8, 1'b0, 32'd6, 32'd3, 1'b0});
    send_request('{ecpad_pkg::OP_DBL, 32'd6, 32'd0, 1'b0, 32'd1, 32'd1, 1'b0});
    send_request('{ecpad_pkg::OP_DBL, 32'd6, 32'd4, 1'b1, 32'd1, 32'd1, 1'b1});
    send_request('{ecpad_pkg::OP_DBL, '1, '1, 1'b0, '1, '1, 1'b1});
    send_request('{ecpad_pkg::OP_ADD, '1, '1, 1'b0, '0, '0, 1'b0});
    send_request('{ecpad_pkg::OP_ADD, 32'hFFFFFFFA, 32'd1, 1'b0, 32'd0, 32'd3, 1'b0});
    send_request('{ecpad_pkg::OP_ADD, 32'hFFFFFFFB, 32'd1, 1'b0, 32'd0, 32'd3, 1'b0});
    send_request('{ecpad_pkg::OP_DBL, 32'hFFFFFFFB, 32'h5, 1'b0, 32'd0, 32'd0, 1'b0});
    send_request('{ecpad_pkg::OP_DBL, 32'h0, 32'hFFFFFFFA, 1'b0,
                   32'hAAAAAAAA, 32'h55555555, 1'b0});
    send_request('{ecpad_pkg::OP_ADD, 32'h55555555, 32'hAAAAAAAA, 1'b0,
                   32'hAAAAAAAA, 32'h55555555, 1'b0});
    drain_results();
    run_random(190);

    // Small prime, then a modulus of 3 with the widest coefficient
    write_reg(ecpad_pkg::REG_MODULUS, 32'd97);
    write_reg(ecpad_pkg::REG_COEFF_A, 32'd5);
    run_random(200);
    write_reg(ecpad_pkg::REG_MODULUS, 32'd3);
    write_reg(ecpad_pkg::REG_COEFF_A, 32'hFFFFFFFF);
    run_random(200);

    // Largest modulus is not prime, so some inverses fail
    write_reg(ecpad_pkg::REG_MODULUS, 32'hFFFFFFFF);
    write_reg(ecpad_pkg::REG_COEFF_A, 32'd7);
    run_random(200);
    write_reg(ecpad_pkg::REG_MODULUS, ecpad_pkg::MODULUS_RESET);
    write_reg(ecpad_pkg::REG_COEFF_A, 32'hFFFFFFFF);
    run_random(220);
    write_reg(ecpad_pkg::REG_MODULUS, 32'd65521);
    write_reg(ecpad_pkg::REG_COEFF_A, 32'd0);
    run_random(220);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (points.errors == 0 && points.expected_points.size() == 0)
      $display("[ec_point_add_double] OK");
    else
      $display("[ec_point_add_double] ERROR");
    $finish;
  end

endmodule

### filelist.f
src/ecpad_pkg.sv
src/ec_point_add_double.sv
tb/sv/ec_point_add_double_test.sv
